[rtl/sss_pkg.sv]
// Shared types and codes for the sorting stack store.
// No dependencies; imported by every module of the block.
package sss_pkg;

	localparam int WORD_W = 32;

	typedef enum logic [2:0] {
		OP_PUSH  = 3'd0,
		OP_POP   = 3'd1,
		OP_READ  = 3'd2,
		OP_CLEAR = 3'd3,
		OP_SORT  = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SORT
	} state_t;

	// broadcast controls from the sequencer to every cell
	typedef struct packed {
		logic push;      // write in_value into the cell at the fill point
		logic rd_load;   // copy each word into its readout register
		logic rd_shift;  // move the readout chain one cell toward cell 0
		logic swap;      // odd-even transposition step
		logic phase;     // which pairs compare this step
	} cell_ctl_t;

endpackage

[rtl/sorting_stack_store.sv]
// Top level of the sorting stack store: a row of sss_cell word cells
// driven by the sss_ctrl sequencer. Depends on sss_pkg.
//
//  channel  dir  tdata fields (low bit first)              width
//  s_*      in   opcode[2:0] value[34:3] slot[38:35] pad  40
//  m_*      out  data_out[31:0] count[36:32] status[38:37] pad  40
//
// Push, clear, unused opcodes and error results load the result register in the accepting cycle.
// Read and pop copy every word into the readout chain; the word at slot (for pop, at
// the new count) then walks the readout chain one cell per cycle toward cell 0.
// Sort runs DEPTH odd-even transposition steps across the cells
// between the accepting cycle and the result cycle.
// One transaction at a time; a pending result that is not taken holds off
// s_tready. Reset empties the store; word contents stay as they were.
module sorting_stack_store import sss_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // opcode[2:0], value[34:3], slot[38:35]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // data_out[31:0], count[36:32], status[38:37]
);

	localparam int CW = $clog2(DEPTH+1);

	cell_ctl_t ctl;
	logic [CW-1:0] count;
	logic signed [WORD_W-1:0] word_w [DEPTH];
	logic signed [WORD_W-1:0] rd_w [DEPTH];
	logic signed [WORD_W-1:0] in_value;
	logic signed [WORD_W-1:0] out_data;
	logic [4:0] out_count;
	logic [1:0] out_status;

	assign in_value = $signed(s_tdata[34:3]);

	sss_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.opcode     (s_tdata[2:0]),
		.slot       (s_tdata[38:35]),
		.rd0        (rd_w[0]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (out_data),
		.out_count  (out_count),
		.out_status (out_status),
		.ctl        (ctl),
		.count      (count)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [WORD_W-1:0] lo_word, hi_word, rd_hi;
		if (i == 0) begin : g_lo0
			assign lo_word = '0;
		end else begin : g_lo
			assign lo_word = word_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_hi0
			assign hi_word = '0;
			assign rd_hi   = '0;
		end else begin : g_hi
			assign hi_word = word_w[i+1];
			assign rd_hi   = rd_w[i+1];
		end
		sss_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.count    (count),
			.in_value (in_value),
			.lo_word  (lo_word),
			.hi_word  (hi_word),
			.rd_hi    (rd_hi),
			.word     (word_w[i]),
			.rd       (rd_w[i])
		);
	end

	assign m_tdata = {1'b0, out_status, out_count, out_data};

endmodule

[rtl/sss_cell.sv]
// One storage cell of the stack: a word, its compare-exchange with the
// neighbors and one stage of the readout chain. Depends on sss_pkg.
module sss_cell import sss_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int IDX   = 0
) (
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic [$clog2(DEPTH+1)-1:0] count,
	input  logic signed [WORD_W-1:0] in_value,
	input  logic signed [WORD_W-1:0] lo_word,
	input  logic signed [WORD_W-1:0] hi_word,
	input  logic signed [WORD_W-1:0] rd_hi,
	output logic signed [WORD_W-1:0] word,
	output logic signed [WORD_W-1:0] rd
);

	localparam int CW = $clog2(DEPTH+1);
	localparam logic PAR = IDX % 2 == 1;

	logic signed [WORD_W-1:0] word_q;
	logic signed [WORD_W-1:0] rd_q;
	logic hit, lower, upper;

	// lower: this cell is the bottom of an active pair; upper: the top
	always_comb begin
		hit   = CW'(IDX) == count;
		lower = ctl.swap && (IDX < DEPTH - 1) && (PAR == ctl.phase)
			&& (CW'(IDX + 1) < count);
		upper = ctl.swap && (IDX >= 1) && (PAR != ctl.phase)
			&& (CW'(IDX) < count);
	end

	always_ff @(posedge clk) begin
		if (ctl.push && hit) begin
			word_q <= in_value;
		end else if (lower && (word_q > hi_word)) begin
			word_q <= hi_word;
		end else if (upper && (lo_word > word_q)) begin
			word_q <= lo_word;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_load) begin
			rd_q <= word_q;
		end else if (ctl.rd_shift) begin
			rd_q <= rd_hi;
		end
	end

	assign word = word_q;
	assign rd   = rd_q;

endmodule

[rtl/sss_ctrl.sv]
// Sequencer of the sorting stack store: fill count, operation decode,
// readout and sort step counters, result register. Depends on sss_pkg.
module sss_ctrl import sss_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2:0]                 opcode,
	input  logic [3:0]                 slot,
	input  logic signed [WORD_W-1:0]   rd0,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [WORD_W-1:0]   out_data,
	output logic [4:0]                 out_count,
	output logic [1:0]                 out_status,
	output cell_ctl_t                  ctl,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int CW = $clog2(DEPTH+1);
	localparam int IW = $clog2(DEPTH);

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] pass_q, pass_d;
	logic [IW-1:0] sel_q, sel_d;
	logic [IW-1:0] k_q, k_d;
	logic out_valid_q;
	logic signed [WORD_W-1:0] out_data_q;
	logic [4:0] out_count_q;
	logic [1:0] out_status_q;

	logic out_free, load;
	logic signed [WORD_W-1:0] res_data;
	status_t res_status;
	logic [CW-1:0] cnt_m1;
	logic [31:0] slot32, count32, next32;

	always_comb begin
		out_free = !out_valid_q || out_ready;
		cnt_m1   = count_q - CW'(1);
		slot32   = 32'(slot);
		count32  = 32'(count_q);
		state_d  = state_q;
		count_d  = count_q;
		pass_d   = pass_q;
		sel_d    = sel_q;
		k_d      = k_q;
		load     = 1'b0;
		res_data = '0;
		res_status = STAT_OK;
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = out_free;
				if (in_valid && out_free) begin
					case (opcode)
						OP_PUSH: begin
							load = 1'b1;
							if (count_q == CW'(DEPTH)) begin
								res_status = STAT_FULL;
							end else begin
								ctl.push = 1'b1;
								count_d  = count_q + CW'(1);
							end
						end
						OP_POP: begin
							if (count_q == '0) begin
								load       = 1'b1;
								res_status = STAT_EMPTY;
							end else begin
								count_d     = cnt_m1;
								sel_d       = cnt_m1[IW-1:0];
								k_d         = '0;
								ctl.rd_load = 1'b1;
								state_d     = S_READ;
							end
						end
						OP_READ: begin
							if (slot32 >= count32) begin
								load       = 1'b1;
								res_status = STAT_RANGE;
							end else begin
								sel_d       = slot32[IW-1:0];
								k_d         = '0;
								ctl.rd_load = 1'b1;
								state_d     = S_READ;
							end
						end
						OP_CLEAR: begin
							count_d = '0;
							load    = 1'b1;
						end
						OP_SORT: begin
							pass_d  = '0;
							state_d = S_SORT;
						end
						default: load = 1'b1;
					endcase
				end
			end
			S_READ: begin
				// the selected word reaches cell 0 after sel shifts
				if (k_q == sel_q) begin
					if (out_free) begin
						load     = 1'b1;
						res_data = rd0;
						state_d  = S_IDLE;
					end
				end else begin
					ctl.rd_shift = 1'b1;
					k_d          = k_q + IW'(1);
				end
			end
			S_SORT: begin
				// DEPTH alternating phases order any fill level
				if (pass_q == CW'(DEPTH)) begin
					if (out_free) begin
						load    = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					ctl.swap  = 1'b1;
					ctl.phase = pass_q[0];
					pass_d    = pass_q + CW'(1);
				end
			end
			default: state_d = S_IDLE;
		endcase
		next32 = 32'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pass_q <= pass_d;
		sel_q  <= sel_d;
		k_q    <= k_d;
		if (load) begin
			out_data_q   <= res_data;
			out_count_q  <= next32[4:0];
			out_status_q <= res_status;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;
	assign out_count  = out_count_q;
	assign out_status = out_status_q;
	assign count      = count_q;

endmodule

[rtl/sss_checker.sv]
// Port-level checks for sorting_stack_store, bound to the top level.
// Depends on sss_pkg.
module sss_checker import sss_pkg::*; #(
	parameter int DEPTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	localparam int       DW   = 32;
	localparam logic [4:0] FULL_CNT = 5'(DEPTH);

	logic [31:0] out_data;
	logic [4:0]  out_count;
	logic [1:0]  out_status;

	assign out_data   = m_tdata[31:0];
	assign out_count  = m_tdata[36:32];
	assign out_status = m_tdata[38:37];

	// a result that is not taken stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// the single result slot must be free before a new transaction enters
	a_one_pending: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while result slot blocked");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (out_status != STAT_OK) |-> out_data == DW'(0))
		else $error("error result carries data");

	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (out_status == STAT_EMPTY) |-> out_count == 5'd0)
		else $error("empty status with nonzero count");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (out_status == STAT_FULL) |-> out_count == FULL_CNT)
		else $error("full status with count below depth");

endmodule

bind sorting_stack_store sss_checker #(.DEPTH(DEPTH)) u_sss_checker (.*);
